// File: rtl/core/pfc_pkg.sv
package pfc_pkg;

  // Default sizes
  localparam int unsigned LengthBitsDef  = 32;
  localparam int unsigned RecordBytesDef = 40;

  // Record phase counter width, covers record sizes up to 64 bytes
  localparam int unsigned PhaseW = 6;

  // Header layout
  localparam int unsigned LenFirstOfs = 2;
  localparam int unsigned LenLastOfs  = 5;
  localparam int unsigned TypeOfs     = 6;
  localparam int unsigned RecordOfs   = 9;
  localparam int unsigned MinLength   = 9;

  // Packet type codes
  localparam logic [7:0] TypeFull     = 8'd0;
  localparam logic [7:0] TypeMinA     = 8'd1;
  localparam logic [7:0] TypeShort    = 8'd3;
  localparam logic [7:0] TypeMinB     = 8'd4;
  localparam logic [7:0] TypeFixedA   = 8'd252;
  localparam logic [7:0] TypeRecords  = 8'd253;
  localparam logic [7:0] TypeFixedB   = 8'd254;
  localparam logic [7:0] TypeFixedC   = 8'd255;

  // Length rules per type
  localparam int unsigned LenFull     = 9 + 69;
  localparam int unsigned LenShort    = 9 + 2;
  localparam int unsigned LenFixedA   = 9 + 21;
  localparam int unsigned LenFixedB   = 9 + 5;
  localparam int unsigned LenFixedC   = 9 + 1;
  localparam int unsigned LenMinA     = 9 + 16;
  localparam int unsigned LenMinB     = 9 + 5;
  localparam int unsigned LenRecBase  = 9 + 2;

  // Result status codes
  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StShort = 2'd1,
    StSum   = 2'd2,
    StType  = 2'd3
  } pfc_status_e;

endpackage

// File: rtl/core/pfc_len_rule.sv
module pfc_len_rule #(
  parameter int unsigned LENGTH_BITS  = pfc_pkg::LengthBitsDef,
  parameter int unsigned RECORD_BYTES = pfc_pkg::RecordBytesDef
) (
  input  logic [LENGTH_BITS-1:0] length_i,
  input  logic [7:0]             type_i,
  input  logic                   phase_zero_i,
  output logic                   fits_o
);
  import pfc_pkg::*;

  localparam int unsigned RecMin = LenRecBase + RECORD_BYTES;

  // Check the advertised length against the rule of its type
  always_comb begin
    case (type_i)
      TypeFull:    fits_o = (length_i == LENGTH_BITS'(LenFull));
      TypeShort:   fits_o = (length_i == LENGTH_BITS'(LenShort));
      TypeFixedA:  fits_o = (length_i == LENGTH_BITS'(LenFixedA));
      TypeFixedB:  fits_o = (length_i == LENGTH_BITS'(LenFixedB));
      TypeFixedC:  fits_o = (length_i == LENGTH_BITS'(LenFixedC));
      TypeMinA:    fits_o = (length_i >= LENGTH_BITS'(LenMinA));
      TypeMinB:    fits_o = (length_i >= LENGTH_BITS'(LenMinB));
      TypeRecords: fits_o = (length_i >= LENGTH_BITS'(RecMin)) && phase_zero_i;
      default:     fits_o = 1'b1;
    endcase
  end

endmodule

// File: rtl/core/packet_frame_checker.sv
// Output: a status word is registered and appears on the output in the cycle after the last byte
// of a packet is accepted.
// Throughput: one byte per cycle; input stalls only when a packet-ending byte
// arrives while the previous status word is held by a stalled output.
// Reset: clears the framer state, drops any pending status and enables the
// per-type length check.
module packet_frame_checker #(
  parameter int unsigned LENGTH_BITS  = pfc_pkg::LengthBitsDef,
  parameter int unsigned RECORD_BYTES = pfc_pkg::RecordBytesDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [7:0]               data_byte_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output pfc_pkg::pfc_status_e     status_o,
  output logic [7:0]               packet_type_o,
  output logic [LENGTH_BITS-1:0]   packet_length_o
);
  import pfc_pkg::*;

  localparam int unsigned LW = LENGTH_BITS;

  // Framer state
  logic [LW-1:0]     idx_q, idx_d;
  logic [LW-1:0]     len_q, len_d;
  logic [7:0]        type_q, type_d;
  logic [7:0]        sum1_q, sum1_d;
  logic [7:0]        sum2_q, sum2_d;
  logic              match_q, match_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic              check_q;

  // Result register
  logic              out_valid_q;
  pfc_status_e       status_q, status_d;
  logic [7:0]        ptype_q, ptype_d;
  logic [LW-1:0]     plen_q;

  logic [LW:0]       idx_p1;
  logic [LW+1:0]     idx_p2;
  logic              ends_now;
  logic              in_sum;
  logic              in_fire;
  logic              fits;

  // Position decode from the byte counter and header length
  assign idx_p1   = {1'b0, idx_q} + (LW+1)'(1);
  assign idx_p2   = {2'b00, idx_q} + (LW+2)'(2);
  assign ends_now = (idx_q >= LW'(TypeOfs)) && (idx_p1 >= {1'b0, len_q});
  assign in_sum   = (idx_q <= LW'(TypeOfs)) || (idx_p2 < {2'b00, len_q});

  // Hold only a packet-ending word that meets a stalled result
  assign in_stall_o = ends_now && out_valid_q && out_stall_i;
  assign in_fire    = in_valid_i && !in_stall_o;

  pfc_len_rule #(
    .LENGTH_BITS  (LENGTH_BITS),
    .RECORD_BYTES (RECORD_BYTES)
  ) u_len_rule (
    .length_i     (len_q),
    .type_i       (type_q),
    .phase_zero_i (phase_q == '0),
    .fits_o       (fits)
  );

  // Next framer state and result for the word on the input
  always_comb begin
    idx_d    = idx_q + LW'(1);
    len_d    = len_q;
    type_d   = type_q;
    sum1_d   = sum1_q;
    sum2_d   = sum2_q;
    match_d  = match_q;
    phase_d  = phase_q;
    ptype_d  = (idx_q == LW'(TypeOfs)) ? data_byte_i : type_q;

    if (idx_q < LW'(MinLength - 1)) begin
      status_d = StShort;
    end else if (!match_q || (data_byte_i != sum2_q)) begin
      status_d = StSum;
    end else if (check_q && !fits) begin
      status_d = StType;
    end else begin
      status_d = StOk;
    end

    if ((idx_q >= LW'(LenFirstOfs)) && (idx_q <= LW'(LenLastOfs))) begin
      len_d = {len_q[LW-9:0], data_byte_i};
    end
    if (idx_q == LW'(TypeOfs)) begin
      type_d = data_byte_i;
    end

    if (ends_now) begin
      idx_d   = '0;
      len_d   = '0;
      type_d  = '0;
      sum1_d  = '0;
      sum2_d  = '0;
      match_d = 1'b0;
      phase_d = '0;
    end else if (in_sum) begin
      sum1_d = sum1_q + data_byte_i;
      sum2_d = sum2_q + sum1_d;
      if (idx_q >= LW'(RecordOfs)) begin
        phase_d = (phase_q == PhaseW'(RECORD_BYTES - 1)) ? '0 : phase_q + PhaseW'(1);
      end
    end else if (idx_p2 == {2'b00, len_q}) begin
      match_d = (data_byte_i == sum1_q);
    end
  end

  // Advance the framer on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      len_q   <= '0;
      type_q  <= '0;
      sum1_q  <= '0;
      sum2_q  <= '0;
      match_q <= 1'b0;
      phase_q <= '0;
    end else if (in_fire) begin
      idx_q   <= idx_d;
      len_q   <= len_d;
      type_q  <= type_d;
      sum1_q  <= sum1_d;
      sum2_q  <= sum2_d;
      match_q <= match_d;
      phase_q <= phase_d;
    end
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_q <= 1'b1;
    end else if (cfg_we_i) begin
      check_q <= cfg_data_i;
    end
  end

  // Result valid: set on a packet end, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && ends_now) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (in_fire && ends_now) begin
      status_q <= status_d;
      ptype_q  <= ptype_d;
      plen_q   <= len_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign packet_type_o   = ptype_q;
  assign packet_length_o = plen_q;

  // A packet-ending word always yields a result next cycle
  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && ends_now |=> out_valid_o)
    else $error("packet end produced no status word");

  // The byte counter steps by one inside a packet
  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !ends_now |=> idx_q == $past(idx_q) + LW'(1))
    else $error("byte counter did not advance");

  // The framer restarts after a packet end
  a_idx_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && ends_now |=> (idx_q == '0) && (len_q == '0) && (phase_q == '0))
    else $error("framer state not cleared after packet end");

  // A good status only comes with a packet of at least the minimum length
  a_ok_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == StOk) |-> packet_length_o >= LW'(MinLength))
    else $error("good status on a short packet");

endmodule
